// File: rtl/ccp_pkg.sv
// Shared types and constants of the cell command parser.
package ccp_pkg;

    localparam int unsigned CmdWidth   = 3;
    localparam int unsigned CellWidth  = 8;
    localparam int unsigned QtyWidth   = 2;
    localparam int unsigned ValueWidth = 16;
    localparam int unsigned CfgIdxWidth = 2;

    // Command codes of a result item.
    localparam logic [CmdWidth-1:0] CMD_SET        = 3'd0;
    localparam logic [CmdWidth-1:0] CMD_REMOVE     = 3'd1;
    localparam logic [CmdWidth-1:0] CMD_REMOVE_ALL = 3'd2;
    localparam logic [CmdWidth-1:0] CMD_ADD        = 3'd3;
    localparam logic [CmdWidth-1:0] CMD_DUMP       = 3'd4;
    localparam logic [CmdWidth-1:0] CMD_MEASURE    = 3'd5;

    // Quantity codes of a set command.
    localparam logic [QtyWidth-1:0] QTY_VOLT = 2'd0;
    localparam logic [QtyWidth-1:0] QTY_CURR = 2'd1;
    localparam logic [QtyWidth-1:0] QTY_TEMP = 2'd2;
    localparam logic [QtyWidth-1:0] QTY_EXPO = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] REG_DEF_VOLTAGE  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_DEF_CURRENT  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_DEF_EXPOSURE = 2'd2;

    localparam logic [ValueWidth-1:0] DEF_VOLTAGE_RST  = 16'd4000;
    localparam logic [ValueWidth-1:0] DEF_CURRENT_RST  = 16'd3000;
    localparam logic [ValueWidth-1:0] DEF_EXPOSURE_RST = 16'd100;

    // ASCII characters the parser reacts to.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_C = 8'h63;
    localparam logic [7:0] CH_LOW_D = 8'h64;
    localparam logic [7:0] CH_LOW_M = 8'h6d;
    localparam logic [7:0] CH_LOW_R = 8'h72;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_SELECT = 11'b000_0000_0010,
        ST_AWAIT  = 11'b000_0000_0100,
        ST_VOLT   = 11'b000_0000_1000,
        ST_CURR   = 11'b000_0001_0000,
        ST_TEMP   = 11'b000_0010_0000,
        ST_EXPO   = 11'b000_0100_0000,
        ST_ADD    = 11'b000_1000_0000,
        ST_DUMP   = 11'b001_0000_0000,
        ST_MEAS   = 11'b010_0000_0000,
        ST_REMOVE = 11'b100_0000_0000
    } ccp_state_t;

    // What one accepted byte produces: nothing, one record, or the add burst.
    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_ONE  = 2'd1,
        RES_ADD  = 2'd2
    } ccp_res_kind_t;

    typedef struct packed {
        ccp_res_kind_t        kind;
        logic [CmdWidth-1:0]   command;
        logic [CellWidth-1:0]  target_cell;
        logic [QtyWidth-1:0]   quantity;
        logic [ValueWidth-1:0] value;
    } ccp_res_t;

endpackage

// File: rtl/ccp_parser.sv
// Command byte parser: parser state registers and the per-byte decode.
module ccp_parser
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                rx_byte,
    input  logic [ccp_pkg::CellWidth-1:0] new_cell_id,
    output ccp_pkg::ccp_res_t         res
);
    import ccp_pkg::*;

    ccp_state_t            state_reg, state_next;
    logic [CellWidth-1:0]  cell_reg, cell_next;
    logic [ValueWidth-1:0] acc_reg, acc_next;
    logic                  seen_reg, seen_next;

    logic                  digit;
    logic [3:0]            dval;
    logic [CellWidth-1:0]  cell_mac;
    logic [ValueWidth-1:0] acc_mac;

    assign digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign dval  = digit ? rx_byte[3:0] : 4'd0;

    // Times ten as two shifted copies, wrapping at the register width.
    assign cell_mac = {cell_reg[CellWidth-4:0], 3'b000} + {cell_reg[CellWidth-2:0], 1'b0}
                    + {{(CellWidth-4){1'b0}}, dval};
    assign acc_mac  = {acc_reg[ValueWidth-4:0], 3'b000} + {acc_reg[ValueWidth-2:0], 1'b0}
                    + {{(ValueWidth-4){1'b0}}, dval};

    always_comb
    begin
        state_next      = state_reg;
        cell_next       = cell_reg;
        acc_next        = acc_reg;
        seen_next       = seen_reg;
        res.kind        = RES_NONE;
        res.command     = CMD_SET;
        res.target_cell = '0;
        res.quantity    = QTY_VOLT;
        res.value       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_byte == CH_LOW_C || rx_byte == CH_LOW_R || rx_byte == CH_LOW_A)
                begin
                    cell_next = '0;
                    seen_next = 1'b0;
                    if (rx_byte == CH_LOW_C)
                        state_next = ST_SELECT;
                    else if (rx_byte == CH_LOW_R)
                        state_next = ST_REMOVE;
                    else
                        state_next = ST_ADD;
                end
                else if (rx_byte == CH_LOW_D)
                    state_next = ST_DUMP;
                else if (rx_byte == CH_LOW_M)
                    state_next = ST_MEAS;
            end
            ST_SELECT:
            begin
                if (digit)
                begin
                    cell_next = cell_mac;
                    seen_next = 1'b1;
                end
                else
                    state_next = seen_reg ? ST_AWAIT : ST_IDLE;
            end
            ST_AWAIT:
            begin
                if (rx_byte == CH_U || rx_byte == CH_I || rx_byte == CH_T || rx_byte == CH_E)
                begin
                    seen_next = 1'b0;
                    acc_next  = '0;
                    if (rx_byte == CH_U)
                        state_next = ST_VOLT;
                    else if (rx_byte == CH_I)
                        state_next = ST_CURR;
                    else if (rx_byte == CH_T)
                        state_next = ST_TEMP;
                    else
                        state_next = ST_EXPO;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_VOLT, ST_CURR, ST_TEMP, ST_EXPO:
            begin
                if (digit)
                begin
                    acc_next  = acc_mac;
                    seen_next = 1'b1;
                end
                else
                begin
                    res.kind        = RES_ONE;
                    res.command     = CMD_SET;
                    res.target_cell = cell_reg;
                    res.value       = acc_reg;
                    if (state_reg == ST_VOLT)
                        res.quantity = QTY_VOLT;
                    else if (state_reg == ST_CURR)
                        res.quantity = QTY_CURR;
                    else if (state_reg == ST_TEMP)
                        res.quantity = QTY_TEMP;
                    else
                        res.quantity = QTY_EXPO;
                    seen_next  = 1'b0;
                    state_next = ST_AWAIT;
                end
            end
            ST_REMOVE:
            begin
                if (digit)
                begin
                    cell_next = cell_mac;
                    seen_next = 1'b1;
                end
                else if (rx_byte == CH_LOW_A)
                begin
                    // An 'a' after digits is dropped without a record.
                    if (!seen_reg)
                    begin
                        res.kind    = RES_ONE;
                        res.command = CMD_REMOVE_ALL;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    res.kind        = RES_ONE;
                    res.command     = CMD_REMOVE;
                    res.target_cell = cell_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                cell_next       = new_cell_id;
                res.kind        = RES_ADD;
                res.command     = CMD_ADD;
                res.target_cell = new_cell_id;
                state_next      = ST_AWAIT;
            end
            ST_DUMP:
            begin
                res.kind    = RES_ONE;
                res.command = CMD_DUMP;
                state_next  = ST_IDLE;
            end
            ST_MEAS:
            begin
                res.kind    = RES_ONE;
                res.command = CMD_MEASURE;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cell_reg  <= '0;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            cell_reg  <= cell_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// File: rtl/ccp_out.sv
// Result register with the step counter that plays out the add burst.
module ccp_out
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  ccp_pkg::ccp_res_t              res,
    input  logic [ccp_pkg::ValueWidth-1:0] def_voltage,
    input  logic [ccp_pkg::ValueWidth-1:0] def_current,
    input  logic [ccp_pkg::ValueWidth-1:0] def_exposure,
    input  logic                           out_stall,
    output logic                           busy,
    output logic                           out_valid,
    output logic [ccp_pkg::CmdWidth-1:0]   command,
    output logic [ccp_pkg::CellWidth-1:0]  cell_res,
    output logic [ccp_pkg::QtyWidth-1:0]   quantity,
    output logic [ccp_pkg::ValueWidth-1:0] value,
    output logic                           last
);
    import ccp_pkg::*;

    logic                  valid_reg, valid_next;
    logic                  last_reg, last_next;
    logic [2:0]            step_reg, step_next;
    logic [CmdWidth-1:0]   cmd_reg, cmd_next;
    logic [CellWidth-1:0]  cell_reg, cell_next;
    logic [QtyWidth-1:0]   qty_reg, qty_next;
    logic [ValueWidth-1:0] value_reg, value_next;
    logic                  taken;

    assign taken = valid_reg && !out_stall;
    // A new byte may enter once the final record of the held one leaves.
    assign busy  = valid_reg && !(taken && last_reg);

    always_comb
    begin
        valid_next = valid_reg;
        last_next  = last_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        cell_next  = cell_reg;
        qty_next   = qty_reg;
        value_next = value_reg;
        if (load && res.kind != RES_NONE)
        begin
            valid_next = 1'b1;
            step_next  = '0;
            cmd_next   = res.command;
            cell_next  = res.target_cell;
            qty_next   = res.quantity;
            value_next = res.value;
            last_next  = (res.kind == RES_ONE);
        end
        else if (taken && last_reg)
        begin
            valid_next = 1'b0;
        end
        else if (taken)
        begin
            // Next default set of the add burst; the cell stays the same.
            step_next = step_reg + 3'd1;
            cmd_next  = CMD_SET;
            qty_next  = step_reg[1:0];
            last_next = (step_reg == 3'd3);
            case (step_reg)
                3'd0:    value_next = def_voltage;
                3'd1:    value_next = def_current;
                default: value_next = def_exposure;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        cell_reg  <= cell_next;
        qty_reg   <= qty_next;
        value_reg <= value_next;
    end

    assign out_valid = valid_reg;
    assign command   = cmd_reg;
    assign cell_res  = cell_reg;
    assign quantity  = qty_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule

// File: rtl/cell_command_parser_top.sv
// Cell command parser top level: configuration registers, parser and result stage.
//
// Input channel: one received command byte (rx_byte) with the cell identifier to
// use if it completes an add (new_cell_id), taken when in_valid is high and
// in_stall is low. Output channel: command records (command, cell_res, quantity,
// value, last), taken when out_valid is high and out_stall is low; last marks the
// final record caused by a byte.
// A byte is decoded in the cycle it is accepted and its first record is valid on
// the next cycle. One byte per cycle is taken while the receiver keeps up. A byte
// that completes an add gives five records from the result stage, one per cycle
// while the receiver keeps up, and the input is held until the last is taken.
// While the receiver stalls the held record stays put, and in_stall stays high
// until the final record of the current byte is taken.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 default
// voltage, 1 default current, 2 default exposure); other indexes are ignored.
// Reset puts the parser in idle, clears the cell number and value, empties the
// result stage and loads the defaults 4000, 3000 and 100.
module cell_command_parser_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ccp_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [ccp_pkg::ValueWidth-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        rx_byte,
    input  logic [ccp_pkg::CellWidth-1:0]     new_cell_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ccp_pkg::CmdWidth-1:0]      command,
    output logic [ccp_pkg::CellWidth-1:0]     cell_res,
    output logic [ccp_pkg::QtyWidth-1:0]      quantity,
    output logic [ccp_pkg::ValueWidth-1:0]    value,
    output logic                              last
);
    import ccp_pkg::*;

    logic [ValueWidth-1:0] def_voltage_reg;
    logic [ValueWidth-1:0] def_current_reg;
    logic [ValueWidth-1:0] def_exposure_reg;
    logic                  accept;
    logic                  busy;
    ccp_res_t              res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_voltage_reg  <= DEF_VOLTAGE_RST;
            def_current_reg  <= DEF_CURRENT_RST;
            def_exposure_reg <= DEF_EXPOSURE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEF_VOLTAGE:  def_voltage_reg  <= cfg_data;
                REG_DEF_CURRENT:  def_current_reg  <= cfg_data;
                REG_DEF_EXPOSURE: def_exposure_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    ccp_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .new_cell_id (new_cell_id),
        .res         (res)
    );

    ccp_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .res          (res),
        .def_voltage  (def_voltage_reg),
        .def_current  (def_current_reg),
        .def_exposure (def_exposure_reg),
        .out_stall    (out_stall),
        .busy         (busy),
        .out_valid    (out_valid),
        .command      (command),
        .cell_res     (cell_res),
        .quantity     (quantity),
        .value        (value),
        .last         (last)
    );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the cell command parser: byte stimulus, command prediction and checks.
module tb_top;
    import ccp_pkg::*;

    localparam logic [CfgIdxWidth-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 80;
    localparam int STUCK_LIMIT = 3000;

    typedef struct packed {
        logic [CmdWidth-1:0]   command;
        logic [CellWidth-1:0]  target_cell;
        logic [QtyWidth-1:0]   quantity;
        logic [ValueWidth-1:0] value;
        logic                  last;
    } cmd_record_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [ValueWidth-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             rx_byte;
    logic [CellWidth-1:0]   new_cell_id;
    logic                   out_valid;
    logic                   out_stall;
    logic [CmdWidth-1:0]    command;
    logic [CellWidth-1:0]   cell_res;
    logic [QtyWidth-1:0]    quantity;
    logic [ValueWidth-1:0]  value;
    logic                   last;

    cell_command_parser_top u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .new_cell_id (new_cell_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .command     (command),
        .cell_res    (cell_res),
        .quantity    (quantity),
        .value       (value),
        .last        (last)
    );

    // Parser mirror, starting from the reset state.
    ccp_state_t            parse_st   = ST_IDLE;
    logic [CellWidth-1:0]  cell_num   = '0;
    logic [ValueWidth-1:0] val_acc    = '0;
    logic                  seen_digit = 1'b0;
    logic [ValueWidth-1:0] dflt_volt  = DEF_VOLTAGE_RST;
    logic [ValueWidth-1:0] dflt_curr  = DEF_CURRENT_RST;
    logic [ValueWidth-1:0] dflt_expo  = DEF_EXPOSURE_RST;

    cmd_record_t expected_records[$];
    int          fail_count   = 0;
    int          items_sent   = 0;
    int          noise_sent   = 0;
    int          burst_left   = 0;
    bit          gaps_on      = 1'b0;
    int          stall_pct    = 0;
    logic        hold_trigger = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_record(input logic [CmdWidth-1:0] cmd,
                                        input logic [CellWidth-1:0] tgt,
                                        input logic [QtyWidth-1:0] qty,
                                        input logic [ValueWidth-1:0] val);
        cmd_record_t rec;
        rec.command     = cmd;
        rec.target_cell = tgt;
        rec.quantity    = qty;
        rec.value       = val;
        rec.last        = 1'b0;
        expected_records.push_back(rec);
    endfunction

    // Advances the parser mirror by one byte and queues the command records it yields.
    function automatic void parse_command_byte(input logic [7:0] b, input logic [7:0] id);
        logic                 is_digit;
        logic [7:0]           d;
        logic [QtyWidth-1:0]  qty;
        int                   queued_before;
        cmd_record_t          tail;
        is_digit = (b >= CH_0) && (b <= CH_9);
        d = b - CH_0;
        queued_before = expected_records.size();
        case (parse_st)
            ST_IDLE:
            begin
                if (b == CH_LOW_C || b == CH_LOW_R || b == CH_LOW_A)
                begin
                    cell_num = '0;
                    seen_digit = 1'b0;
                    if (b == CH_LOW_C)
                        parse_st = ST_SELECT;
                    else if (b == CH_LOW_R)
                        parse_st = ST_REMOVE;
                    else
                        parse_st = ST_ADD;
                end
                else if (b == CH_LOW_D)
                    parse_st = ST_DUMP;
                else if (b == CH_LOW_M)
                    parse_st = ST_MEAS;
            end
            ST_SELECT:
            begin
                if (is_digit)
                begin
                    cell_num = 8'(cell_num * 10 + d);
                    seen_digit = 1'b1;
                end
                else if (seen_digit)
                    parse_st = ST_AWAIT;
                else
                    parse_st = ST_IDLE;
            end
            ST_AWAIT:
            begin
                if (b == CH_U || b == CH_I || b == CH_T || b == CH_E)
                begin
                    seen_digit = 1'b0;
                    val_acc = '0;
                    if (b == CH_U)
                        parse_st = ST_VOLT;
                    else if (b == CH_I)
                        parse_st = ST_CURR;
                    else if (b == CH_T)
                        parse_st = ST_TEMP;
                    else
                        parse_st = ST_EXPO;
                end
                else
                    parse_st = ST_IDLE;
            end
            ST_VOLT, ST_CURR, ST_TEMP, ST_EXPO:
            begin
                if (is_digit)
                begin
                    val_acc = 16'(val_acc * 10 + d);
                    seen_digit = 1'b1;
                end
                else
                begin
                    case (parse_st)
                        ST_VOLT: qty = QTY_VOLT;
                        ST_CURR: qty = QTY_CURR;
                        ST_TEMP: qty = QTY_TEMP;
                        default: qty = QTY_EXPO;
                    endcase
                    push_record(CMD_SET, cell_num, qty, val_acc);
                    seen_digit = 1'b0;
                    parse_st = ST_AWAIT;
                end
            end
            ST_REMOVE:
            begin
                if (is_digit)
                begin
                    cell_num = 8'(cell_num * 10 + d);
                    seen_digit = 1'b1;
                end
                else if (b == CH_LOW_A)
                begin
                    // A trailing 'a' after a cell number cancels the remove.
                    if (!seen_digit)
                        push_record(CMD_REMOVE_ALL, '0, '0, '0);
                    parse_st = ST_IDLE;
                end
                else
                begin
                    push_record(CMD_REMOVE, cell_num, '0, '0);
                    parse_st = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                cell_num = id;
                push_record(CMD_ADD, id, '0, '0);
                push_record(CMD_SET, id, QTY_VOLT, dflt_volt);
                push_record(CMD_SET, id, QTY_CURR, dflt_curr);
                push_record(CMD_SET, id, QTY_TEMP, dflt_expo);
                push_record(CMD_SET, id, QTY_EXPO, dflt_expo);
                parse_st = ST_AWAIT;
            end
            ST_DUMP:
            begin
                push_record(CMD_DUMP, '0, '0, '0);
                parse_st = ST_IDLE;
            end
            ST_MEAS:
            begin
                push_record(CMD_MEASURE, '0, '0, '0);
                parse_st = ST_IDLE;
            end
            default: parse_st = ST_IDLE;
        endcase
        if (expected_records.size() > queued_before)
        begin
            tail = expected_records.pop_back();
            tail.last = 1'b1;
            expected_records.push_back(tail);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        cmd_record_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("unexpected result: command %0d cell %0d quantity %0d value %0d",
                           command, cell_res, quantity, value);
                    fail_count++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    if (command !== want.command)
                    begin
                        $error("command: expected %0d, got %0d", want.command, command);
                        fail_count++;
                    end
                    if (cell_res !== want.target_cell)
                    begin
                        $error("cell_res: expected %0d, got %0d", want.target_cell, cell_res);
                        fail_count++;
                    end
                    if (quantity !== want.quantity)
                    begin
                        $error("quantity: expected %0d, got %0d", want.quantity, quantity);
                        fail_count++;
                    end
                    if (value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, value);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DEF_VOLTAGE:  dflt_volt = cfg_data;
                    REG_DEF_CURRENT:  dflt_curr = cfg_data;
                    REG_DEF_EXPOSURE: dflt_expo = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                parse_command_byte(rx_byte, new_cell_id);
        end
    end

    always @(posedge clk)
    begin : watchdog
        int stuck;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck = 0;
        else
        begin
            stuck++;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off whenever the trigger toggles.
    initial
    begin : receiver
        logic hold_seen;
        int   hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [7:0] id);
        if (gaps_on && burst_left == 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        new_cell_id <= id;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (burst_left != 0)
            burst_left--;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], rnd_byte());
    endtask

    task automatic release_input();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        burst_left = 0;
    endtask

    // Lets every queued record come out, then idles on for bytes that yield none.
    task automatic wait_drained();
        release_input();
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_default(input logic [CfgIdxWidth-1:0] idx,
                                 input logic [ValueWidth-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_digit();
        return CH_0 + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_nondigit();
        logic [7:0] b;
        do b = rnd_byte(); while (b >= CH_0 && b <= CH_9);
        return b;
    endfunction

    function automatic logic [7:0] pick_qty_letter();
        case ($urandom_range(3))
            0: return CH_U;
            1: return CH_I;
            2: return CH_T;
            default: return CH_E;
        endcase
    endfunction

    function automatic logic [7:0] pick_not_qty();
        logic [7:0] b;
        do b = rnd_byte(); while (b == CH_U || b == CH_I || b == CH_T || b == CH_E);
        return b;
    endfunction

    task automatic send_value_entry();
        send_byte(pick_qty_letter(), rnd_byte());
        // Up to six digits so the value wraps past 16 bits now and then.
        repeat ($urandom_range(0, 6)) send_byte(pick_digit(), rnd_byte());
        send_byte(pick_nondigit(), rnd_byte());
    endtask

    // One mostly well-formed command with random content, or a stray byte.
    task automatic send_random_command();
        int kind;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            send_byte(CH_LOW_C, rnd_byte());
            repeat ($urandom_range(0, 4)) send_byte(pick_digit(), rnd_byte());
            send_byte(pick_nondigit(), rnd_byte());
            repeat ($urandom_range(1, 3)) send_value_entry();
            send_byte(pick_not_qty(), rnd_byte());
        end
        else if (kind < 55)
        begin
            send_byte(CH_LOW_A, rnd_byte());
            send_byte(rnd_byte(), rnd_byte());
            repeat ($urandom_range(0, 2)) send_value_entry();
            send_byte(pick_not_qty(), rnd_byte());
        end
        else if (kind < 75)
        begin
            send_byte(CH_LOW_R, rnd_byte());
            repeat ($urandom_range(0, 3)) send_byte(pick_digit(), rnd_byte());
            if ($urandom_range(99) < 30)
                send_byte(CH_LOW_A, rnd_byte());
            else
                send_byte(pick_nondigit(), rnd_byte());
        end
        else if (kind < 90)
        begin
            send_byte(($urandom_range(1) != 0) ? CH_LOW_D : CH_LOW_M, rnd_byte());
            send_byte(rnd_byte(), rnd_byte());
        end
        else
        begin
            send_byte(rnd_byte(), rnd_byte());
            noise_sent++;
        end
    endtask

    task automatic test_directed_commands();
        gaps_on = 1'b0;
        stall_pct <= 0;
        // Add with reset defaults, largest byte and largest identifier.
        send_byte(CH_LOW_A, 8'h00);
        send_byte(8'hFF, 8'hFF);
        // Largest value; a letter ending the digits is consumed, not a new quantity.
        send_text("U65535E!");
        // Cell number wraps at 8 bits; a set with no digits carries value zero.
        send_text("c300;T/q");
        // Select with no digit goes back to idle.
        send_text("cz");
        // Remove all, cancelled remove, and remove with no digit.
        send_text("rar7a");
        send_byte(CH_LOW_R, 8'hAA);
        send_byte(8'h00, 8'h55);
        send_byte(CH_LOW_D, 8'h0F);
        send_byte(8'h80, 8'hF0);
        send_text("m9");
        wait_drained();
    endtask

    task automatic test_default_registers();
        logic [ValueWidth-1:0] v;
        int s;
        gaps_on = 1'b1;
        stall_pct <= 30;
        for (s = 0; s < 4; s++)
        begin
            v = (s == 0) ? 16'h0000 : (s == 1) ? 16'hFFFF : 16'($urandom_range(65535));
            write_default(REG_DEF_VOLTAGE, (s < 2) ? v : 16'($urandom_range(65535)));
            write_default(REG_DEF_CURRENT, (s < 2) ? v : 16'($urandom_range(65535)));
            write_default(REG_DEF_EXPOSURE, v);
            // The spare index must not disturb any default.
            write_default(REG_SPARE, 16'($urandom_range(65535)));
            send_byte(CH_LOW_A, rnd_byte());
            send_byte(rnd_byte(), rnd_byte());
            send_byte(pick_not_qty(), rnd_byte());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        int target;
        gaps_on = 1'b0;
        stall_pct <= 0;
        hold_trigger <= ~hold_trigger;
        target = items_sent + 40;
        while (items_sent < target)
            send_random_command();
        // Sender stops until the block has handed over every record.
        wait_drained();
        gaps_on = 1'b1;
        stall_pct <= 50;
        target = items_sent + 10;
        while (items_sent < target)
            send_random_command();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int phase;
        int target;
        for (phase = 0; phase < 4; phase++)
        begin
            gaps_on = (phase == 1 || phase == 2);
            stall_pct <= (phase == 0) ? 0 : (phase == 1) ? 30 : (phase == 2) ? 70 : 50;
            write_default(REG_DEF_VOLTAGE, 16'($urandom_range(65535)));
            write_default(REG_DEF_CURRENT, 16'($urandom_range(65535)));
            write_default(REG_DEF_EXPOSURE, 16'($urandom_range(65535)));
            target = items_sent - noise_sent + 85;
            while (items_sent - noise_sent < target)
                send_random_command();
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        rx_byte = '0;
        new_cell_id = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_commands();
        test_default_registers();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_records.size() != 0)
        begin
            $error("%0d expected records never arrived", expected_records.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ccp_pkg.sv
rtl/ccp_parser.sv
rtl/ccp_out.sv
rtl/cell_command_parser_top.sv
tb/sv/tb_top.sv
